// File: hdl/pswt_pkg.sv
// Package for the priority schedule wait-times core.
// Holds the input and result word types, the stored entry type and defaults.
// No dependencies.
package pswt_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 5;
  localparam int TIME_W  = 20;
  localparam int AVG_W   = 28;
  localparam int FRAC_W  = 8;

  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  priority_req;
    logic               is_last;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    process_id;
    logic [BURST_W-1:0] burst_time_out;
    logic [PRIO_W-1:0]  priority_out;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [AVG_W-1:0]   average_wait;
    logic [AVG_W-1:0]   average_turnaround;
    logic               last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hdl/pswt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module pswt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pswt_div.sv
// Restoring divider, one quotient bit per cycle.
// No package dependencies; used by priority_schedule_wait_times_core.
module pswt_div #(
  parameter int DIVD_W = 34,
  parameter int DVS_W  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in one dividend bit, subtract where the divisor fits
      quo_nxt = {quo_r[DIVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/priority_schedule_wait_times_core.sv
// Top level of the nonpreemptive priority scheduler core.
// Depends on pswt_pkg, pswt_ram (entry store) and pswt_div (average divider).
//
//   channel | ports                       | word        | handshake
//   --------+-----------------------------+-------------+---------------------------
//   input   | start, busy, in_word        | in_word_t   | taken when start && !busy
//   result  | out_valid, out_word         | out_word_t  | one cycle per word, no stall
//
// Loading takes one word per cycle. A word with is_last set starts a run of
// n loaded processes: the exchange sort streams the store through one read and
// one write port, then the totals pass runs, then the shared divider runs twice
// on a dividend of DW = sum width + 8 bits, then the result pass runs. busy
// stays high for the whole run. Reset clears the controller and the load count;
// the store needs no clearing since only entries loaded in the current run are
// read. The receiver cannot stall: each result word is flagged by out_valid for
// exactly one cycle.
module priority_schedule_wait_times_core #(
  parameter int MAX_PROCS = pswt_pkg::MAX_PROCS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pswt_pkg::in_word_t  in_word,
  output logic                out_valid,
  output pswt_pkg::out_word_t out_word
);

  import pswt_pkg::*;

  localparam int CW = $clog2(MAX_PROCS + 1);                  // count width
  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1; // store address
  localparam int WW = BURST_W + CW;                           // running wait
  localparam int SW = WW + CW;                                // sum of waits
  localparam int DW = SW + FRAC_W;                            // divider dividend

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDI    = 4'd1;
  localparam logic [3:0] S_LDI    = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_WRI    = 4'd4;
  localparam logic [3:0] S_SUMRD  = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_DIVWGO = 4'd7;
  localparam logic [3:0] S_DIVW   = 4'd8;
  localparam logic [3:0] S_DIVTGO = 4'd9;
  localparam logic [3:0] S_DIVT   = 4'd10;
  localparam logic [3:0] S_OUTRD  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  entry_t         cur_r, cur_nxt;
  logic [WW-1:0]  wait_r, wait_nxt;
  logic [SW-1:0]  sumw_r, sumw_nxt;
  logic [AVG_W-1:0] avgw_r, avgw_nxt;
  logic [AVG_W-1:0] avgt_r, avgt_nxt;
  logic           ov_r, ov_nxt;
  out_word_t      ow_r, ow_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  logic [CW-1:0]  ram_raddr;
  entry_t         rd;
  logic [ENTRY_W-1:0] rd_bits;

  logic           div_start;
  logic [DW-1:0]  div_dividend;
  logic           div_done;
  logic [DW-1:0]  div_quo;

  logic           accept;
  logic           room;
  logic [CW-1:0]  last_idx;

  assign accept   = start && !busy;
  assign room     = (count_r < CW'(MAX_PROCS));
  assign last_idx = n_r - CW'(1);
  assign rd       = entry_t'(rd_bits);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    wait_nxt     = wait_r;
    sumw_nxt     = sumw_r;
    avgw_nxt     = avgw_r;
    avgt_nxt     = avgt_r;
    ov_nxt       = 1'b0;
    ow_nxt       = ow_r;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_wdata    = cur_r;
    ram_raddr    = '0;
    div_start    = 1'b0;
    div_dividend = {sumw_r, FRAC_W'(0)};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // store the word while there is room, drop it otherwise
          ram_wdata.id    = ID_W'(count_r + CW'(1));
          ram_wdata.prio  = in_word.priority_req;
          ram_wdata.burst = in_word.burst_time;
          ram_we          = room;
          count_nxt       = room ? count_r + CW'(1) : count_r;
          if (in_word.is_last) begin
            n_nxt     = count_nxt;
            count_nxt = '0;
            i_nxt     = '0;
            if (n_nxt >= CW'(2)) begin
              state_nxt = S_RDI;
            end else if (n_nxt == CW'(1)) begin
              state_nxt = S_SUMRD;
            end
          end
        end
      end
      S_RDI: begin
        ram_raddr = i_r;
        state_nxt = S_LDI;
      end
      S_LDI: begin
        // hold slot i in a register, start streaming the later slots
        cur_nxt   = rd;
        j_nxt     = i_r + CW'(1);
        ram_raddr = i_r + CW'(1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ram_raddr = j_r + CW'(1);
        if (cur_r.prio > rd.prio) begin
          // swap: old slot i goes to j, slot j becomes the held one
          ram_we    = 1'b1;
          ram_waddr = j_r[AW-1:0];
          ram_wdata = cur_r;
          cur_nxt   = rd;
        end
        if (j_r == last_idx) begin
          state_nxt = S_WRI;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = cur_r;
        i_nxt     = i_r + CW'(1);
        if ({1'b0, i_r} + (CW+1)'(2) < {1'b0, n_r}) begin
          state_nxt = S_RDI;
        end else begin
          state_nxt = S_SUMRD;
        end
      end
      S_SUMRD: begin
        ram_raddr = '0;
        k_nxt     = '0;
        wait_nxt  = '0;
        sumw_nxt  = '0;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // accumulate waits; total turnaround is sum of waits plus final wait
        ram_raddr = k_r + CW'(1);
        sumw_nxt  = sumw_r + SW'(wait_r);
        wait_nxt  = wait_r + WW'(rd.burst);
        if (k_r == last_idx) begin
          state_nxt = S_DIVWGO;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_DIVWGO: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          avgw_nxt  = AVG_W'(div_quo);
          state_nxt = S_DIVTGO;
        end
      end
      S_DIVTGO: begin
        div_dividend = {SW'(sumw_r + SW'(wait_r)), FRAC_W'(0)};
        div_start    = 1'b1;
        state_nxt    = S_DIVT;
      end
      S_DIVT: begin
        if (div_done) begin
          avgt_nxt  = AVG_W'(div_quo);
          state_nxt = S_OUTRD;
        end
      end
      S_OUTRD: begin
        ram_raddr = '0;
        k_nxt     = '0;
        wait_nxt  = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // emit one word per cycle in schedule order
        ram_raddr                 = k_r + CW'(1);
        ov_nxt                    = 1'b1;
        ow_nxt.process_id         = rd.id;
        ow_nxt.burst_time_out     = rd.burst;
        ow_nxt.priority_out       = rd.prio;
        ow_nxt.wait_time          = TIME_W'(wait_r);
        ow_nxt.turnaround_time    = TIME_W'(wait_r + WW'(rd.burst));
        ow_nxt.average_wait       = avgw_r;
        ow_nxt.average_turnaround = avgt_r;
        ow_nxt.last_of_run        = (k_r == last_idx);
        wait_nxt                  = wait_r + WW'(rd.burst);
        if (k_r == last_idx) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    cur_r  <= cur_nxt;
    wait_r <= wait_nxt;
    sumw_r <= sumw_nxt;
    avgw_r <= avgw_nxt;
    avgt_r <= avgt_nxt;
    ow_r   <= ow_nxt;
  end

  pswt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr[AW-1:0]),
    .rdata (rd_bits)
  );

  pswt_div #(
    .DIVD_W (DW),
    .DVS_W  (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

// File: tb/sv/tb_priority_schedule_wait_times_core.sv
// Self-checking testbench for priority_schedule_wait_times_core.
// Uses pswt_pkg for the word types and a local scheduler model for expected results.
// Covers a directed stimulus table first, then random runs under several sender idle rates.
`timescale 1ns / 1ps

module tb_priority_schedule_wait_times_core;
  import pswt_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_WORDS  = 300;
  localparam int DRAIN_CYCLES  = 400;   // well past the slowest run of sixteen processes
  localparam int STALL_LIMIT   = 3000;  // cycles with no word taken and no result seen

  // One row of the directed table: the word to send, and an optional typed result.
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // Scheduler model state: the loaded process table and its fill count.
  entry_t      proc_slots[MAX_PROCS_DEF];
  int unsigned proc_count;

  out_word_t   fresh_words[$];   // results of the word just taken
  out_word_t   due_words[$];     // results still to arrive, oldest first
  dir_row_t    dir_rows[$];

  int unsigned err_count;
  int unsigned words_taken;
  int unsigned words_dropped;
  int unsigned runs_started;
  int unsigned results_seen;
  int unsigned quiet_cycles;

  priority_schedule_wait_times_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Load one process into the model; on is_last, sort the table and fill fresh_words.
  task automatic schedule_word(input in_word_t w);
    int unsigned n;
    int unsigned i;
    int unsigned j;
    entry_t      tmp;
    bit [63:0]   run_wait;
    bit [63:0]   sum_wait;
    bit [63:0]   sum_turn;
    bit [63:0]   quot;
    logic [AVG_W-1:0] avg_wait;
    logic [AVG_W-1:0] avg_turn;
    out_word_t   r;
    fresh_words = {};
    // Store while there is room; drop silently once the table is full.
    if (proc_count < MAX_PROCS_DEF) begin
      proc_slots[proc_count].burst = w.burst_time;
      proc_slots[proc_count].prio  = w.priority_req;
      proc_slots[proc_count].id    = ID_W'(proc_count + 1);
      proc_count++;
    end else begin
      words_dropped++;
    end
    if (w.is_last) begin
      n = proc_count;
      proc_count = 0;
      if (n != 0) begin
        runs_started++;
        // Exchange sort: swap only on a strictly greater priority value.
        for (i = 0; i + 1 < n; i++) begin
          for (j = i + 1; j < n; j++) begin
            if (proc_slots[i].prio > proc_slots[j].prio) begin
              tmp = proc_slots[i];
              proc_slots[i] = proc_slots[j];
              proc_slots[j] = tmp;
            end
          end
        end
        run_wait = 0;
        sum_wait = 0;
        sum_turn = 0;
        for (i = 0; i < n; i++) begin
          sum_wait += run_wait;
          sum_turn += run_wait + proc_slots[i].burst;
          run_wait += proc_slots[i].burst;
        end
        // Averages carry eight fraction bits, truncated.
        quot = (sum_wait << FRAC_W) / n;
        avg_wait = quot[AVG_W-1:0];
        quot = (sum_turn << FRAC_W) / n;
        avg_turn = quot[AVG_W-1:0];
        run_wait = 0;
        for (i = 0; i < n; i++) begin
          r.process_id         = proc_slots[i].id;
          r.burst_time_out     = proc_slots[i].burst;
          r.priority_out       = proc_slots[i].prio;
          r.wait_time          = run_wait[TIME_W-1:0];
          quot                 = run_wait + proc_slots[i].burst;
          r.turnaround_time    = quot[TIME_W-1:0];
          r.average_wait       = avg_wait;
          r.average_turnaround = avg_turn;
          r.last_of_run        = (i + 1 == n);
          fresh_words.push_back(r);
          run_wait += proc_slots[i].burst;
        end
      end
    end
  endtask

  // Send one word: idle first at the given rate, then hold start until the word is taken.
  // A typed result replaces what the model predicts for that word.
  task automatic send_word(input in_word_t w, input int unsigned idle_pct,
                           input bit typed, input out_word_t typed_word);
    logic [31:0] junk;
    // Idle cycles: drop start and put noise on the bus, which must be ignored.
    while ($urandom_range(99) < idle_pct) begin
      junk = $urandom;
      start   <= 1'b0;
      in_word <= junk[$bits(in_word_t)-1:0];
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The word is taken at this edge.
    words_taken++;
    schedule_word(w);
    if (typed) begin
      due_words.push_back(typed_word);
    end else begin
      foreach (fresh_words[k]) due_words.push_back(fresh_words[k]);
    end
  endtask

  function automatic in_word_t mk_word(input int unsigned burst, input int unsigned prio,
                                       input bit last);
    in_word_t w;
    w.burst_time   = BURST_W'(burst);
    w.priority_req = PRIO_W'(prio);
    w.is_last      = last;
    return w;
  endfunction

  function automatic dir_row_t mk_row(input in_word_t w);
    dir_row_t row;
    row.word   = w;
    row.typed  = 1'b0;
    row.result = '0;
    return row;
  endfunction

  // Result checker: every strobed word must match the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %h", out_word));
      end else begin
        want = due_words.pop_front();
        if (out_word.process_id !== want.process_id)
          report_mismatch($sformatf("process_id got %0d want %0d",
                                    out_word.process_id, want.process_id));
        if (out_word.burst_time_out !== want.burst_time_out)
          report_mismatch($sformatf("burst_time_out got %0d want %0d",
                                    out_word.burst_time_out, want.burst_time_out));
        if (out_word.priority_out !== want.priority_out)
          report_mismatch($sformatf("priority_out got %0d want %0d",
                                    out_word.priority_out, want.priority_out));
        if (out_word.wait_time !== want.wait_time)
          report_mismatch($sformatf("wait_time got %0d want %0d",
                                    out_word.wait_time, want.wait_time));
        if (out_word.turnaround_time !== want.turnaround_time)
          report_mismatch($sformatf("turnaround_time got %0d want %0d",
                                    out_word.turnaround_time, want.turnaround_time));
        if (out_word.average_wait !== want.average_wait)
          report_mismatch($sformatf("average_wait got %0d want %0d",
                                    out_word.average_wait, want.average_wait));
        if (out_word.average_turnaround !== want.average_turnaround)
          report_mismatch($sformatf("average_turnaround got %0d want %0d",
                                    out_word.average_turnaround, want.average_turnaround));
        if (out_word.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %0d want %0d",
                                    out_word.last_of_run, want.last_of_run));
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results pending",
               STALL_LIMIT, due_words.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t    row;
    in_word_t    w;
    int unsigned n;
    int unsigned k;
    int unsigned idle_pct;
    int unsigned pick;
    int unsigned burst;
    int unsigned prio;
    bit          tie_mode;
    int unsigned rand_sent;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    proc_count   = 0;
    err_count    = 0;
    words_taken  = 0;
    words_dropped = 0;
    runs_started = 0;
    results_seen = 0;
    quiet_cycles = 0;
    rand_sent    = 0;

    // Directed table. Single-process runs at the extremes carry typed results.
    row = mk_row(mk_word(0, 0, 1'b1));
    row.typed  = 1'b1;
    row.result = '{process_id: 1, burst_time_out: 0, priority_out: 0, wait_time: 0,
                   turnaround_time: 0, average_wait: 0, average_turnaround: 0,
                   last_of_run: 1'b1};
    dir_rows.push_back(row);
    row = mk_row(mk_word(65535, 255, 1'b1));
    row.typed  = 1'b1;
    row.result = '{process_id: 1, burst_time_out: 16'hFFFF, priority_out: 8'hFF,
                   wait_time: 0, turnaround_time: 20'd65535, average_wait: 0,
                   average_turnaround: 28'd16776960, last_of_run: 1'b1};
    dir_rows.push_back(row);
    // Equal priorities: the exchange sort may reorder ties.
    dir_rows.push_back(mk_row(mk_word(10, 5, 1'b0)));
    dir_rows.push_back(mk_row(mk_word(20, 5, 1'b0)));
    dir_rows.push_back(mk_row(mk_word(30, 1, 1'b1)));
    // Two processes, worst priority first.
    dir_rows.push_back(mk_row(mk_word(100, 255, 1'b0)));
    dir_rows.push_back(mk_row(mk_word(1, 0, 1'b1)));
    // Full table of maximum bursts, then two words past capacity; the dropped
    // is_last word still starts the run.
    for (k = 0; k < MAX_PROCS_DEF; k++)
      dir_rows.push_back(mk_row(mk_word(65535, MAX_PROCS_DEF - 1 - k, 1'b0)));
    dir_rows.push_back(mk_row(mk_word(5, 0, 1'b0)));
    dir_rows.push_back(mk_row(mk_word(7, 0, 1'b1)));

    // Hold reset, then release it on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_word(dir_rows[r].word, 0, dir_rows[r].typed, dir_rows[r].result);

    // Random runs: mostly small, some large up to full, a few past capacity.
    while (rand_sent < RANDOM_WORDS) begin
      // Phases of sender idling: none, heavy, light.
      case (rand_sent * 3 / RANDOM_WORDS)
        0:       idle_pct = 0;
        1:       idle_pct = 53;
        default: idle_pct = 8;
      endcase
      pick = $urandom_range(99);
      if (pick < 70)      n = $urandom_range(6, 1);
      else if (pick < 92) n = $urandom_range(MAX_PROCS_DEF, 7);
      else                n = $urandom_range(MAX_PROCS_DEF + 3, MAX_PROCS_DEF + 1);
      tie_mode = ($urandom_range(2) == 0);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(9))
          0:       burst = 0;
          1:       burst = 65535;
          2:       burst = $urandom_range(15);
          default: burst = $urandom_range(65535);
        endcase
        if (tie_mode) prio = ($urandom_range(1) == 0) ? $urandom_range(3)
                                                      : $urandom_range(255, 252);
        else          prio = $urandom_range(255);
        w = mk_word(burst, prio, (k + 1 == n));
        send_word(w, idle_pct, 1'b0, '0);
        rand_sent++;
      end
    end

    // Release the bus and let every expected result come out.
    start   <= 1'b0;
    in_word <= '0;
    while (due_words.size() != 0) @(posedge clk);
    // Watch a while longer for stray result words.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words in %0d runs, %0d dropped past capacity",
             words_taken, runs_started, words_dropped);
    $display("checked %0d result words, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
